// ===== design/vbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared types and constants for the variable-byte codec.
// ----------------------------------------------------------------------------
package vbc_pkg;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned MAX_BYTES  = 10;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned SHAMT_W    = 6;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [VALUE_W-1:0] in_value;
		logic [BYTE_W-1:0]  in_byte;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic [VALUE_W-1:0] out_value;
		logic               last;
		logic               overflow;
	} out_t;

	typedef enum logic {
		ST_IDLE,
		ST_ENCODE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic enc_load;
		logic enc_emit;
		logic dec_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic enc_more;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/vbc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_ctrl
// Mode register and state machine that sequences encode and decode work.
// ----------------------------------------------------------------------------
module vbc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire vbc_pkg::stat_t stat,
	output vbc_pkg::cmd_t      cmd
);
	import vbc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				// a decode byte may finish a group, so it needs a free output slot
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					if (mode_q == MODE_DECODE) begin
						cmd.dec_step = 1'b1;
					end else begin
						cmd.enc_load = 1'b1;
						state_d      = ST_ENCODE;
					end
				end
			end
			ST_ENCODE: begin
				if (stat.out_free) begin
					cmd.enc_emit = 1'b1;
					if (!stat.enc_more) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/vbc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbc_dp
// Encode shifter, decode accumulator and the output register.
// ----------------------------------------------------------------------------
module vbc_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vbc_pkg::cmd_t cmd,
	output vbc_pkg::stat_t     stat,
	input  wire vbc_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output vbc_pkg::out_t      out_data
);
	import vbc_pkg::*;

	// encode side
	logic [VALUE_W-1:0] shift_q;
	logic [CNT_W-1:0]   enc_cnt_q;
	logic               enc_last;
	logic [BYTE_W-1:0]  enc_byte;

	// decode side
	logic [VALUE_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [VALUE_W-1:0] acc_d;
	logic               ovf_d;
	logic [SHAMT_W-1:0] shamt;
	logic               dec_room;
	logic               dec_stop;

	logic               out_valid_q;
	out_t               out_q;

	assign stat.out_free = !out_valid_q || out_ready;

	// more bytes follow while bits remain above the low group, capped at ten bytes
	assign stat.enc_more = (shift_q[VALUE_W-1:GROUP_BITS] != '0)
		&& (enc_cnt_q < CNT_W'(MAX_BYTES - 1));
	assign enc_last = !stat.enc_more;
	assign enc_byte = {enc_last, shift_q[GROUP_BITS-1:0]};

	assign dec_room = cnt_q < CNT_W'(MAX_BYTES);
	assign dec_stop = in_data.in_byte[BYTE_W-1];
	assign shamt    = SHAMT_W'(cnt_q) * SHAMT_W'(GROUP_BITS);

	// groups never overlap, so the add is an or; bits past 64 fall off the shift
	always_comb begin
		acc_d = acc_q;
		ovf_d = ovf_q;
		if (dec_room) begin
			acc_d = acc_q | (VALUE_W'(in_data.in_byte[GROUP_BITS-1:0]) << shamt);
		end else begin
			ovf_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_cnt_q <= '0;
		end else if (cmd.enc_load) begin
			enc_cnt_q <= '0;
		end else if (cmd.enc_emit) begin
			enc_cnt_q <= enc_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enc_load) begin
			shift_q <= in_data.in_value;
		end else if (cmd.enc_emit) begin
			shift_q <= shift_q >> GROUP_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.dec_step) begin
			if (dec_stop) begin
				acc_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				acc_q <= acc_d;
				ovf_q <= ovf_d;
				if (dec_room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.enc_emit || (cmd.dec_step && dec_stop)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enc_emit) begin
			out_q.out_byte  <= enc_byte;
			out_q.out_value <= '0;
			out_q.last      <= enc_last;
			out_q.overflow  <= 1'b0;
		end else if (cmd.dec_step && dec_stop) begin
			out_q.out_byte  <= '0;
			out_q.out_value <= acc_d;
			out_q.last      <= 1'b0;
			out_q.overflow  <= ovf_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== design/vbyte_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbyte_codec
// Variable-byte integer codec, encode or decode picked by a mode register.
//
// cfg_we/cfg_wdata write the mode bit (0 encode, 1 decode); write it only
// while the block is idle. Input and output channels use valid/ready, a
// transfer happening when both are high. In encode mode an input value
// gives one to ten output bytes, low group first, the final one with bit 7
// and last set: the value is loaded, then one shift register gives the bytes
// one a cycle while the output is free; no new value is taken until the final
// byte is sent. In decode mode one byte is taken each cycle while the output
// register is free; the byte with bit 7 set loads the gathered value into the
// output register at its own transfer, so the result is valid from the next
// cycle. A single output register holds each result; while the receiver
// stalls the encoder pauses and no new input is taken until that register
// frees. Reset clears the mode to encode, the decode state and out_valid.
// ----------------------------------------------------------------------------
module vbyte_codec (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire vbc_pkg::in_t in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output vbc_pkg::out_t  out_data
);
	import vbc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	vbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
